// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock, held off during reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed: label");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed: label");

`endif

// ===== rtl/ptt_pkg.sv =====
`default_nettype none
package ptt_pkg;
	localparam int CAPACITY = 16;
	localparam int ID_BITS  = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [2:0] K_INSERT = 3'd0;
	localparam logic [2:0] K_DELETE = 3'd1;
	localparam logic [2:0] K_UPDATE = 3'd2;
	localparam logic [2:0] K_LIST   = 3'd3;
	localparam logic [2:0] K_SEARCH = 3'd4;

	localparam logic [2:0] RC_OK        = 3'd0;
	localparam logic [2:0] RC_NOT_FOUND = 3'd1;
	localparam logic [2:0] RC_EMPTY     = 3'd2;
	localparam logic [2:0] RC_INVALID   = 3'd3;
	localparam logic [2:0] RC_FULL      = 3'd4;
	localparam logic [2:0] RC_ENTRY     = 3'd5;
	localparam logic [2:0] RC_NONE      = 3'd6;

	localparam logic [1:0] ST_COMPLETED = 2'd2;
	localparam logic [1:0] ST_BAD       = 2'd3;

	// write data select
	localparam logic [1:0] WS_NEW    = 2'd0;
	localparam logic [1:0] WS_READ   = 2'd1;
	localparam logic [1:0] WS_STATUS = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] task_id;
		logic [2:0]  task_priority;
		logic [1:0]  status_code;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  result_code;
		logic [15:0] entry_id;
		logic [2:0]  entry_priority;
		logic [1:0]  entry_status;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic [2:0]         prio;
		logic [1:0]         status;
	} slot_t;

	// controller -> datapath
	typedef struct packed {
		logic             load;     // capture request
		logic             rd;       // read slot at idx
		logic [IDX_W-1:0] idx;
		logic             wr;       // write slot at widx
		logic [IDX_W-1:0] widx;
		logic [1:0]       wsel;     // new entry, read data or status update
		logic             cnt_inc;
		logic             cnt_dec;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [CNT_W-1:0] count;
		slot_t            rdata;
		in_item_t         req;
	} dp_sts_t;
endpackage
`default_nettype wire

// ===== rtl/ptt_datapath.sv =====
`default_nettype none
module ptt_datapath (
	input  wire                 clk,
	input  wire                 arst_n,
	input  ptt_pkg::in_item_t   in_item,
	input  ptt_pkg::dp_cmd_t    cmd,
	output ptt_pkg::dp_sts_t    sts
);
	import ptt_pkg::*;

	slot_t            mem [CAPACITY];
	slot_t            rdata_q;
	in_item_t         req_q;
	logic [CNT_W-1:0] count_q;
	slot_t            wdata;

	always_comb begin
		case (cmd.wsel)
			WS_NEW:  wdata = '{id: req_q.task_id[ID_BITS-1:0], prio: req_q.task_priority,
				status: req_q.status_code};
			WS_READ: wdata = rdata_q;
			default: wdata = '{id: rdata_q.id, prio: rdata_q.prio,
				status: req_q.status_code};
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr)
			mem[cmd.widx] <= wdata;
		if (cmd.rd)
			rdata_q <= mem[cmd.idx];
		if (cmd.load)
			req_q <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign sts = '{count: count_q, rdata: rdata_q, req: req_q};
endmodule
`default_nettype wire

// ===== rtl/ptt_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
module ptt_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire                 out_ready,
	output ptt_pkg::out_item_t  out_item,
	input  ptt_pkg::dp_sts_t    sts,
	output ptt_pkg::dp_cmd_t    cmd
);
	import ptt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_SCAN, S_SCAN_CHK, S_SHIFT, S_SHIFT_WR, S_PLACE,
		S_EMIT, S_FINAL
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] i_q;      // scan/shift position
	logic [CNT_W-1:0] hole_q;   // insert position
	logic [1:0]       grp_q;    // listing group
	logic             found_q;
	logic [2:0]       rc_q;     // code of the final beat
	out_item_t        out_q;
	logic             ovalid_q;
	logic             slot_free;
	logic             out_load;
	in_item_t         rq;
	slot_t            rd;
	logic [CNT_W-1:0] cnt;
	logic             match;

	assign rq  = sts.req;
	assign rd  = sts.rdata;
	assign cnt = sts.count;
	assign slot_free = !ovalid_q || out_ready;
	assign out_load  = slot_free && (state_q == S_EMIT || state_q == S_FINAL);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ovalid_q;
	assign out_item  = out_q;

	always_comb begin
		case (rq.kind) inside
			K_DELETE, K_UPDATE: match = (rd.id == rq.task_id[ID_BITS-1:0]);
			K_LIST:             match = (rd.status == grp_q);
			K_SEARCH:           match = (rd.prio == rq.task_priority);
			default:            match = (rd.prio < rq.task_priority);
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.idx  = i_q[IDX_W-1:0];
		unique case (state_q)
			S_SCAN:  cmd.rd = 1'b1;
			S_SHIFT: begin
				cmd.rd  = 1'b1;
				cmd.idx = (rq.kind == K_INSERT) ? IDX_W'(i_q - CNT_W'(1)) :
					IDX_W'(i_q + CNT_W'(1));
			end
			S_SHIFT_WR: begin
				cmd.wr   = 1'b1;
				cmd.widx = i_q[IDX_W-1:0];
				cmd.wsel = WS_READ;
			end
			S_PLACE: begin
				cmd.wr   = (rq.kind != K_DELETE);
				cmd.widx = i_q[IDX_W-1:0];
				cmd.wsel = (rq.kind == K_INSERT) ? WS_NEW : WS_STATUS;
				cmd.cnt_inc = (rq.kind == K_INSERT);
				cmd.cnt_dec = (rq.kind == K_DELETE);
			end
			default: ;
		endcase
	end

	function automatic out_item_t fin(input logic [2:0] rc, input in_item_t r);
		out_item_t o;
		o = '{result_code: rc, entry_id: r.task_id, entry_priority: 3'd0,
			entry_status: 2'd0, last: 1'b1};
		o.entry_id = 16'(r.task_id[ID_BITS-1:0]);
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			hole_q   <= '0;
			ovalid_q <= 1'b0;
			i_q      <= '0;
			grp_q    <= '0;
			found_q  <= 1'b0;
			rc_q     <= RC_OK;
			out_q    <= '0;
		end else begin
			ovalid_q <= out_load || (ovalid_q && !out_ready);
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_DECODE;
				end
				S_DECODE: begin
					i_q     <= '0;
					grp_q   <= '0;
					found_q <= 1'b0;
					if (rq.kind == K_INSERT && cnt == CNT_W'(CAPACITY)) begin
						rc_q <= RC_FULL; state_q <= S_FINAL;
					end else if ((rq.kind == K_DELETE || rq.kind == K_LIST) && cnt == '0) begin
						rc_q <= RC_EMPTY; state_q <= S_FINAL;
					end else if (rq.kind > K_SEARCH) begin
						state_q <= S_IDLE;
					end else if (cnt == '0) begin
						// nothing to scan
						if (rq.kind == K_INSERT) state_q <= S_PLACE;
						else if (rq.kind == K_UPDATE) begin
							rc_q <= RC_NOT_FOUND; state_q <= S_FINAL;
						end else begin
							rc_q <= RC_NONE; state_q <= S_FINAL;
						end
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: state_q <= S_SCAN_CHK;
				S_SCAN_CHK: begin
					if (match && (rq.kind == K_LIST || rq.kind == K_SEARCH)) begin
						found_q <= 1'b1;
						state_q <= S_EMIT;
					end else if (match && rq.kind == K_INSERT) begin
						// insert position found; open a hole from the tail
						hole_q  <= i_q;
						i_q     <= cnt;
						state_q <= S_SHIFT;
					end else if (match && rq.kind == K_UPDATE) begin
						if (rq.status_code == ST_BAD) begin
							rc_q <= RC_INVALID; state_q <= S_FINAL;
						end else begin
							state_q <= S_PLACE;
						end
					end else if (match && rq.kind == K_DELETE) begin
						state_q <= (i_q + CNT_W'(1) == cnt) ? S_PLACE : S_SHIFT;
					end else if (i_q + CNT_W'(1) != cnt) begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_SCAN;
					end else begin
						unique case (rq.kind) inside
							K_INSERT: begin
								i_q <= cnt; state_q <= S_PLACE;
							end
							K_DELETE, K_UPDATE: begin
								rc_q <= RC_NOT_FOUND; state_q <= S_FINAL;
							end
							K_LIST: begin
								if (grp_q == ST_COMPLETED) begin
									rc_q <= RC_OK; state_q <= S_FINAL;
								end else begin
									grp_q <= grp_q + 2'd1; i_q <= '0; state_q <= S_SCAN;
								end
							end
							default: begin
								rc_q <= found_q ? RC_OK : RC_NONE;
								state_q <= S_FINAL;
							end
						endcase
					end
				end
				S_EMIT: if (slot_free) begin
					out_q <= '{result_code: RC_ENTRY, entry_id: 16'(rd.id),
						entry_priority: rd.prio, entry_status: rd.status, last: 1'b0};
					if (i_q + CNT_W'(1) != cnt) begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_SCAN;
					end else if (rq.kind == K_LIST && grp_q != ST_COMPLETED) begin
						grp_q <= grp_q + 2'd1; i_q <= '0; state_q <= S_SCAN;
					end else begin
						rc_q <= RC_OK; state_q <= S_FINAL;
					end
				end
				S_SHIFT: state_q <= S_SHIFT_WR;
				S_SHIFT_WR: begin
					if (rq.kind == K_INSERT) begin
						i_q <= i_q - CNT_W'(1);
						state_q <= (i_q - CNT_W'(1) == hole_q) ? S_PLACE : S_SHIFT;
					end else begin
						i_q <= i_q + CNT_W'(1);
						state_q <= (i_q + CNT_W'(2) == cnt) ? S_PLACE : S_SHIFT;
					end
				end
				S_PLACE: begin
					rc_q <= RC_OK;
					state_q <= S_FINAL;
				end
				S_FINAL: if (slot_free) begin
					out_q <= fin(rc_q, rq);
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, !in_ready)
	`ASSERT_IMPL(a_no_write_full, clk, arst_n, cmd.cnt_inc, cnt < CNT_W'(CAPACITY))
	`ASSERT_IMPL(a_no_dec_empty, clk, arst_n, cmd.cnt_dec, cnt != '0)
	`ASSERT_NEXT(a_final_last, clk, arst_n, state_q == S_FINAL && slot_free,
		out_valid && out_item.last)
	`ASSERT_NEXT(a_hold_beat, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_item))
endmodule
`default_nettype wire

// ===== rtl/priority_task_table.sv =====
// Sorted task table of CAPACITY entries, kept in descending priority with
// older entries first among equals. One operation is taken at a time; input
// is ready again once the final beat of the previous operation has been
// loaded into the output register. An operation walks the single-port entry
// memory one slot at a time (read, check); a search emits one beat per
// match, and a status listing makes three passes over the table. An output
// stall holds the operation. Each result beat leaves from an output
// register; the final beat of an operation has last set. Kinds 5 to 7 are
// dropped with no result.
`default_nettype none
module priority_task_table (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  ptt_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output ptt_pkg::out_item_t  out_data
);
	import ptt_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	ptt_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .cmd(cmd), .sts(sts)
	);

	ptt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_data),
		.sts(sts), .cmd(cmd)
	);
endmodule
`default_nettype wire

// ===== dv/tb_priority_task_table.sv =====
`timescale 1ns / 1ps
module tb_priority_task_table;
	import ptt_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;

	priority_task_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// table mirror
	slot_t table_q[$];
	out_item_t expected_q[$];
	int errors;
	int cycles;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	initial begin
		cycles = 0;
		// watchdog against a hung run; the bound leaves ample room for stalls
		wait (cycles >= 900000);
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	function automatic out_item_t beat(input logic [2:0] rc, input logic [15:0] id,
			input logic [2:0] p, input logic [1:0] s, input logic l);
		out_item_t o;
		o.result_code = rc;
		o.entry_id = id;
		o.entry_priority = p;
		o.entry_status = s;
		o.last = l;
		return o;
	endfunction

	function automatic int find_task(input logic [15:0] id);
		foreach (table_q[i])
			if (table_q[i].id == id) return i;
		return -1;
	endfunction

	// apply one operation to the mirror and queue its result beats
	task automatic predict_operation(input in_item_t it);
		int pos;
		int hit;
		bit found;
		slot_t s;
		case (it.kind)
			K_INSERT: begin
				if (table_q.size() >= CAPACITY) begin
					expected_q.push_back(beat(RC_FULL, it.task_id, 3'd0, 2'd0, 1'b1));
				end else begin
					pos = 0;
					while (pos < table_q.size() && table_q[pos].prio >= it.task_priority)
						pos++;
					s.id = it.task_id;
					s.prio = it.task_priority;
					s.status = it.status_code;
					table_q.insert(pos, s);
					expected_q.push_back(beat(RC_OK, it.task_id, 3'd0, 2'd0, 1'b1));
				end
			end
			K_DELETE: begin
				hit = find_task(it.task_id);
				if (table_q.size() == 0)
					expected_q.push_back(beat(RC_EMPTY, it.task_id, 3'd0, 2'd0, 1'b1));
				else if (hit < 0)
					expected_q.push_back(beat(RC_NOT_FOUND, it.task_id, 3'd0, 2'd0, 1'b1));
				else begin
					table_q.delete(hit);
					expected_q.push_back(beat(RC_OK, it.task_id, 3'd0, 2'd0, 1'b1));
				end
			end
			K_UPDATE: begin
				hit = find_task(it.task_id);
				if (hit < 0)
					expected_q.push_back(beat(RC_NOT_FOUND, it.task_id, 3'd0, 2'd0, 1'b1));
				else if (it.status_code == ST_BAD)
					expected_q.push_back(beat(RC_INVALID, it.task_id, 3'd0, 2'd0, 1'b1));
				else begin
					table_q[hit].status = it.status_code;
					expected_q.push_back(beat(RC_OK, it.task_id, 3'd0, 2'd0, 1'b1));
				end
			end
			K_LIST: begin
				if (table_q.size() == 0) begin
					expected_q.push_back(beat(RC_EMPTY, it.task_id, 3'd0, 2'd0, 1'b1));
				end else begin
					for (int g = 0; g < 3; g++)
						foreach (table_q[i])
							if (table_q[i].status == 2'(g))
								expected_q.push_back(beat(RC_ENTRY, table_q[i].id,
									table_q[i].prio, table_q[i].status, 1'b0));
					expected_q.push_back(beat(RC_OK, it.task_id, 3'd0, 2'd0, 1'b1));
				end
			end
			K_SEARCH: begin
				found = 0;
				foreach (table_q[i])
					if (table_q[i].prio == it.task_priority) begin
						expected_q.push_back(beat(RC_ENTRY, table_q[i].id,
							table_q[i].prio, table_q[i].status, 1'b0));
						found = 1;
					end
				expected_q.push_back(beat(found ? RC_OK : RC_NONE, it.task_id, 3'd0, 2'd0,
					1'b1));
			end
			default: ;
		endcase
	endtask

	// offer one beat; valid stays high across back-to-back items
	task automatic send_op(input logic [2:0] k, input logic [15:0] id,
			input logic [2:0] p, input logic [1:0] s);
		in_item_t it;
		it.kind = k;
		it.task_id = id;
		it.task_priority = p;
		it.status_code = s;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_operation(it);
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// compare each accepted result beat with the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected beat code", out_data.result_code, -1);
			end else begin
				want = expected_q.pop_front();
				if (out_data.result_code !== want.result_code)
					report_mismatch("result_code", out_data.result_code, want.result_code);
				if (out_data.entry_id !== want.entry_id)
					report_mismatch("entry_id", out_data.entry_id, want.entry_id);
				if (out_data.entry_priority !== want.entry_priority)
					report_mismatch("entry_priority", out_data.entry_priority,
						want.entry_priority);
				if (out_data.entry_status !== want.entry_status)
					report_mismatch("entry_status", out_data.entry_status, want.entry_status);
				if (out_data.last !== want.last)
					report_mismatch("last", out_data.last, want.last);
			end
		end
	end

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_id();
		if (table_q.size() != 0 && $urandom_range(3) != 0)
			return table_q[$urandom_range(table_q.size() - 1)].id;
		return 16'($urandom_range(15));
	endfunction

	task automatic test_empty_table();
		send_op(K_DELETE, 16'h0000, 3'd0, 2'd0);
		send_op(K_UPDATE, 16'hffff, 3'd0, 2'd1);
		send_op(K_LIST, 16'h1234, 3'd0, 2'd0);
		send_op(K_SEARCH, 16'h0001, 3'd3, 2'd0);
		send_op(3'd5, 16'h0, 3'd0, 2'd0);
		send_op(3'd7, 16'hffff, 3'd7, 2'd3);
	endtask

	task automatic test_fill_and_edit();
		// equal priorities, extremes, unrecognized status, duplicate ids
		send_op(K_INSERT, 16'h0000, 3'd0, 2'd0);
		send_op(K_INSERT, 16'hffff, 3'd7, 2'd3);
		send_op(K_INSERT, 16'h0005, 3'd3, 2'd1);
		send_op(K_INSERT, 16'h0005, 3'd3, 2'd2);
		for (int i = 0; i < 13; i++)
			send_op(K_INSERT, 16'(16'h00a0 + i), 3'($urandom_range(1, 5)), 2'(i % 3));
		send_op(K_LIST, 16'h0042, 3'd0, 2'd0);
		send_op(K_SEARCH, 16'h0, 3'd3, 2'd0);
		send_op(K_UPDATE, 16'h0005, 3'd0, 2'd3);
		send_op(K_UPDATE, 16'hffff, 3'd0, 2'd0);
		send_op(K_UPDATE, 16'h7777, 3'd0, 2'd1);
		send_op(K_DELETE, 16'h0005, 3'd0, 2'd0);
		send_op(K_DELETE, 16'h7777, 3'd0, 2'd0);
		send_op(K_LIST, 16'h0, 3'd0, 2'd0);
	endtask

	task automatic test_random_ops(input int n);
		int r;
		logic [2:0] k;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 30) k = K_INSERT;
			else if (r < 50) k = K_DELETE;
			else if (r < 65) k = K_UPDATE;
			else if (r < 77) k = K_LIST;
			else if (r < 95) k = K_SEARCH;
			else k = 3'($urandom_range(5, 7));
			if (k == K_INSERT && $urandom_range(9) == 0)
				send_op(k, 16'($urandom), 3'($urandom), 2'($urandom));
			else if (k == K_INSERT)
				send_op(k, pick_id(), 3'($urandom_range(1, 5)), 2'($urandom_range(2)));
			else
				send_op(k, $urandom_range(4) == 0 ? 16'($urandom) : pick_id(),
					3'($urandom), 2'($urandom));
		end
	endtask

	task automatic test_backpressure();
		// hold output off long enough that the block stalls its input
		recv_stall_pct = 0;
		send_idle_pct = 0;
		hold_cycles = 400;
		test_random_ops(20);
	endtask

	initial begin
		errors = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_fill_and_edit();
		wait_drained();
		test_random_ops(50);
		send_idle_pct = 82;
		test_random_ops(40);
		send_idle_pct = 0;
		recv_stall_pct = 82;
		test_random_ops(40);
		send_idle_pct = 15;
		recv_stall_pct = 15;
		test_random_ops(50);
		test_backpressure();
		wait_drained();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
